@@ sv/s2c_pkg.sv @@
// shared types, constants and month table for the seconds to calendar converter
`default_nettype none

package s2c_pkg;

    localparam int unsigned DAYS_W   = 16;
    localparam int unsigned YEAR_W   = 12;
    localparam int unsigned DOY_W    = 9;

    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
    } t_tod;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day;
    } t_date;

    // first day of year of each month, zero based, one day later from March on in a leap year
    function automatic logic [DOY_W-1:0] month_start(input logic [3:0] idx, input logic leap);
        logic [DOY_W-1:0] base;
        begin
            case (idx)
                4'd0:    base = 9'd0;
                4'd1:    base = 9'd31;
                4'd2:    base = 9'd59;
                4'd3:    base = 9'd90;
                4'd4:    base = 9'd120;
                4'd5:    base = 9'd151;
                4'd6:    base = 9'd181;
                4'd7:    base = 9'd212;
                4'd8:    base = 9'd243;
                4'd9:    base = 9'd273;
                4'd10:   base = 9'd304;
                4'd11:   base = 9'd334;
                default: base = 9'd0;
            endcase
            if (leap && idx >= 4'd2) begin
                base = base + 9'd1;
            end
            return base;
        end
    endfunction

endpackage

`default_nettype wire

@@ sv/seconds_to_calendar_top.sv @@
// top level of the seconds to calendar converter with its register port
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------------
//  request   | start, busy           | i_count_seconds
//  result    | o_valid (strobe)      | o_year_number .. o_second_of_minute
//  config    | psel, penable, pready | paddr, pwdata, prdata (epoch offset)
//
// one request per cycle, every cycle; busy stays low
// result strobe rises as the request's valid bit leaves the last register stage
// divider chain by constants over nine register stages, no state between requests
// reset clears the stage valid bits and the epoch offset
// the receiver cannot stall, so the pipeline never holds
`default_nettype none

module seconds_to_calendar_top #(
    parameter int unsigned START_YEAR = 1980
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_count_seconds,
    output logic             o_valid,
    output logic [11:0]      o_year_number,
    output logic [3:0]       o_month_number,
    output logic [4:0]       o_day_of_month,
    output logic [4:0]       o_hour_of_day,
    output logic [5:0]       o_minute_of_hour,
    output logic [5:0]       o_second_of_minute,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [1:0]  REG_EPOCH_OFFSET = 2'd0;
    localparam int unsigned PIPE_DEPTH       = 9;

    logic [31:0]    r_epoch_offset;
    logic           w_accept;
    logic           w_tod_valid;
    s2c_pkg::t_tod  w_tod;
    s2c_pkg::t_tod  w_out_tod;
    s2c_pkg::t_date w_out_date;

    assign busy     = 1'b0;
    assign pready   = 1'b1;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch_offset <= '0;
        end else if (psel && penable && pwrite && pready && paddr == REG_EPOCH_OFFSET) begin
            r_epoch_offset <= pwdata;
        end
    end

    assign prdata = (paddr == REG_EPOCH_OFFSET) ? r_epoch_offset : '0;

    s2c_time_split u_time_split (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_accept),
        .i_count  (i_count_seconds),
        .i_offset (r_epoch_offset),
        .o_valid  (w_tod_valid),
        .o_tod    (w_tod)
    );

    s2c_date_split #(
        .START_YEAR (START_YEAR)
    ) u_date_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_tod_valid),
        .i_tod   (w_tod),
        .o_valid (o_valid),
        .o_tod   (w_out_tod),
        .o_date  (w_out_date)
    );

    assign o_year_number      = w_out_date.year;
    assign o_month_number     = w_out_date.month;
    assign o_day_of_month     = w_out_date.day;
    assign o_hour_of_day      = w_out_tod.hour;
    assign o_minute_of_hour   = w_out_tod.minute;
    assign o_second_of_minute = w_out_tod.second;

    // every request gives its result after the pipeline depth
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##PIPE_DEPTH o_valid)
        else $error("request without result");

    // no result without a request
    a_result_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, PIPE_DEPTH))
        else $error("result without request");

    // time of day stays in range
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hour_of_day < 5'd24) && (o_minute_of_hour < 6'd60)
                    && (o_second_of_minute < 6'd60))
        else $error("time field out of range");

    // month stays in range
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month_number >= 4'd1) && (o_month_number <= 4'd12))
        else $error("month out of range");

endmodule

`default_nettype wire

@@ sv/s2c_time_split.sv @@
// offset add and split of the second count into days, hour, minute and second
`default_nettype none

module s2c_time_split (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [31:0]       i_count,
    input  wire logic [31:0]       i_offset,
    output logic                   o_valid,
    output s2c_pkg::t_tod          o_tod
);

    localparam logic [31:0] DIV60_MUL   = 32'h8888_8889;
    localparam int unsigned DIV60_SHIFT = 37;
    localparam logic [31:0] DIV3_MUL    = 32'hAAAA_AAAB;
    localparam int unsigned DIV3_SHIFT  = 33;

    logic [4:0]  r_valid;

    logic [31:0] r_s1_sum;
    logic [31:0] r_s2_sum;
    logic [26:0] r_s2_q60;
    logic [5:0]  r_s3_sec;
    logic [26:0] r_s3_q60;
    logic [20:0] r_s3_q3600;
    logic [5:0]  r_s4_sec;
    logic [5:0]  r_s4_min;
    logic [20:0] r_s4_q3600;
    logic [s2c_pkg::DAYS_W-1:0] r_s4_days;
    s2c_pkg::t_tod r_s5_tod;

    logic [63:0] n_prod2;
    logic [63:0] n_prod3;
    logic [49:0] n_prod4;
    logic [31:0] n_sec_full;
    logic [26:0] n_min_full;
    logic [20:0] n_hour_full;

    always_comb begin
        n_prod2     = 64'(r_s1_sum) * 64'(DIV60_MUL);
        n_prod3     = 64'(r_s2_q60) * 64'(DIV60_MUL);
        n_sec_full  = r_s2_sum - (32'(r_s2_q60) * 32'd60);
        n_prod4     = 50'(r_s3_q3600[20:3]) * 50'(DIV3_MUL);
        n_min_full  = r_s3_q60 - (27'(r_s3_q3600) * 27'd60);
        n_hour_full = r_s4_q3600 - (21'(r_s4_days) * 21'd24);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_sum   <= i_count + i_offset;

        r_s2_sum   <= r_s1_sum;
        r_s2_q60   <= 27'(n_prod2 >> DIV60_SHIFT);

        r_s3_sec   <= n_sec_full[5:0];
        r_s3_q60   <= r_s2_q60;
        r_s3_q3600 <= 21'(n_prod3 >> DIV60_SHIFT);

        r_s4_sec   <= r_s3_sec;
        r_s4_min   <= n_min_full[5:0];
        r_s4_q3600 <= r_s3_q3600;
        r_s4_days  <= s2c_pkg::DAYS_W'(n_prod4 >> DIV3_SHIFT);

        r_s5_tod.days   <= r_s4_days;
        r_s5_tod.hour   <= n_hour_full[4:0];
        r_s5_tod.minute <= r_s4_min;
        r_s5_tod.second <= r_s4_sec;
    end

    assign o_valid = r_valid[4];
    assign o_tod   = r_s5_tod;

endmodule

`default_nettype wire

@@ sv/s2c_date_split.sv @@
// split of the day count into year, month and day of month
`default_nettype none

module s2c_date_split #(
    parameter int unsigned START_YEAR = 1980
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire s2c_pkg::t_tod     i_tod,
    output logic                   o_valid,
    output s2c_pkg::t_tod          o_tod,
    output s2c_pkg::t_date         o_date
);

    localparam logic [16:0] CYCLE_MUL   = 17'd91868;
    localparam int unsigned CYCLE_SHIFT = 27;
    localparam logic [10:0] CYCLE_DAYS  = 11'd1461;
    localparam logic [10:0] YEAR1_START = 11'd366;
    localparam logic [10:0] YEAR2_START = 11'd731;
    localparam logic [10:0] YEAR3_START = 11'd1096;

    logic [3:0] r_valid;

    s2c_pkg::t_tod r_s6_tod;
    logic [15:0]   r_s6_days;
    logic [5:0]    r_s6_cycles;
    s2c_pkg::t_tod r_s7_tod;
    logic [10:0]   r_s7_rem;
    logic [5:0]    r_s7_cycles;
    s2c_pkg::t_tod r_s8_tod;
    logic [s2c_pkg::YEAR_W-1:0] r_s8_year;
    logic [s2c_pkg::DOY_W-1:0]  r_s8_doy;
    s2c_pkg::t_tod r_s9_tod;
    s2c_pkg::t_date r_s9_date;

    logic [32:0] n_prod6;
    logic [15:0] n_rem_full;
    logic [1:0]  n_year_in_cycle;
    logic [10:0] n_doy_full;
    logic [s2c_pkg::YEAR_W-1:0] n_year;
    logic        n_leap;
    logic [3:0]  n_month;
    logic [s2c_pkg::DOY_W-1:0] n_start;
    logic [s2c_pkg::DOY_W-1:0] n_day_full;

    always_comb begin
        n_prod6    = 33'(i_tod.days) * 33'(CYCLE_MUL);
        n_rem_full = r_s6_days - (16'(r_s6_cycles) * 16'(CYCLE_DAYS));
    end

    // year within the four year cycle
    always_comb begin
        if (r_s7_rem >= YEAR3_START) begin
            n_year_in_cycle = 2'd3;
            n_doy_full      = r_s7_rem - YEAR3_START;
        end else if (r_s7_rem >= YEAR2_START) begin
            n_year_in_cycle = 2'd2;
            n_doy_full      = r_s7_rem - YEAR2_START;
        end else if (r_s7_rem >= YEAR1_START) begin
            n_year_in_cycle = 2'd1;
            n_doy_full      = r_s7_rem - YEAR1_START;
        end else begin
            n_year_in_cycle = 2'd0;
            n_doy_full      = r_s7_rem;
        end
        n_year = s2c_pkg::YEAR_W'(START_YEAR) + s2c_pkg::YEAR_W'({r_s7_cycles, 2'b00})
               + s2c_pkg::YEAR_W'(n_year_in_cycle);
    end

    // month search over the month start table
    always_comb begin
        n_leap  = (r_s8_year[1:0] == 2'b00);
        n_month = 4'd1;
        n_start = '0;
        for (int i = 0; i < 12; i++) begin
            if (r_s8_doy >= s2c_pkg::month_start(4'(i), n_leap)) begin
                n_month = 4'(i + 1);
                n_start = s2c_pkg::month_start(4'(i), n_leap);
            end
        end
        n_day_full = r_s8_doy - n_start + 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6_tod    <= i_tod;
        r_s6_days   <= i_tod.days;
        r_s6_cycles <= 6'(n_prod6 >> CYCLE_SHIFT);

        r_s7_tod    <= r_s6_tod;
        r_s7_rem    <= n_rem_full[10:0];
        r_s7_cycles <= r_s6_cycles;

        r_s8_tod    <= r_s7_tod;
        r_s8_year   <= n_year;
        r_s8_doy    <= n_doy_full[s2c_pkg::DOY_W-1:0];

        r_s9_tod        <= r_s8_tod;
        r_s9_date.year  <= r_s8_year;
        r_s9_date.month <= n_month;
        r_s9_date.day   <= n_day_full[4:0];
    end

    assign o_valid = r_valid[3];
    assign o_tod   = r_s9_tod;
    assign o_date  = r_s9_date;

endmodule

`default_nettype wire
